// ----- sv/stbg_pkg.sv -----
`default_nettype none
// Constants and types shared by the square tone beep generator.
package stbg_pkg;

	localparam int SAMPLE_RATE    = 16000;
	localparam int SILENCE_FRAMES = 32;
	localparam int FRAMES_PER_MS  = SAMPLE_RATE / 1000;

	localparam int FREQ_W   = 16;
	localparam int MS_W     = 16;
	localparam int GAIN_W   = 17;
	localparam int PERIOD_W = 14;
	localparam int FRAMES_W = 21;
	localparam int TAIL_W   = 6;
	localparam int AMP_W    = 31;
	localparam int SAMPLE_W = 32;
	localparam int DCNT_W   = 4;

	localparam logic [PERIOD_W-1:0] DEFAULT_PERIOD  = PERIOD_W'(36);
	localparam logic [GAIN_W-1:0]   FULL_SCALE_GAIN = GAIN_W'(65536);
	localparam logic [PERIOD_W-1:0] DIVIDEND        = PERIOD_W'(SAMPLE_RATE);

	localparam logic REQ_START = 1'b0;
	localparam logic REQ_TICK  = 1'b1;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       playing;
		logic                       in_tail;
		logic                       last;
	} smp_t;

endpackage
`default_nettype wire

// ----- sv/stbg_ifs.sv -----
`default_nettype none
// Handshake channel interfaces for requests, samples and gain writes.
interface stbg_req_if;
	import stbg_pkg::*;
	logic              valid;
	logic              ready;
	logic              req_type;
	logic [FREQ_W-1:0] freq_hz;
	logic [MS_W-1:0]   duration_ms;
	modport source (output valid, req_type, freq_hz, duration_ms, input ready);
	modport sink   (input valid, req_type, freq_hz, duration_ms, output ready);
endinterface

interface stbg_smp_if;
	import stbg_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       playing;
	logic                       in_tail;
	logic                       last;
	modport source (output valid, sample, playing, in_tail, last, input ready);
	modport sink   (input valid, sample, playing, in_tail, last, output ready);
endinterface

interface stbg_cfg_if;
	import stbg_pkg::*;
	logic              valid;
	logic              ready;
	logic [GAIN_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ----- sv/square_tone_beep_generator.sv -----
`default_nettype none
// Square tone beep generator: start requests and sample ticks in, one sample beat per tick.
// A tick's sample beat is registered into the output queue behind any beat still held.
// A zero-frequency start takes the default period; a nonzero one stalls requests while one
// shared compare-subtract unit forms the period a quotient bit per cycle.
// A two-beat output queue lets ticks be taken while a sample beat is still held.
// arst_n clears the tone state to idle, empties the queue and sets the gain to full scale.
module square_tone_beep_generator (
	input  wire logic clk,
	input  wire logic arst_n,
	stbg_req_if.sink  req,
	stbg_smp_if.source smp,
	stbg_cfg_if.sink  cfg
);
	import stbg_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_DIV  = 1'b1;

	logic                state_q;
	logic [DCNT_W-1:0]   dcnt_q;
	logic [FREQ_W-1:0]   divisor_q;
	logic [FREQ_W-1:0]   rem_q;
	logic [PERIOD_W-1:0] quot_q;

	logic [GAIN_W-1:0]   gain_q;
	logic [PERIOD_W-1:0] period_q;
	logic [PERIOD_W-1:0] phase_q;
	logic [FRAMES_W-1:0] frames_q;
	logic [TAIL_W-1:0]   tail_q;
	logic [AMP_W-1:0]    amp_q;
	logic                busy_q;

	smp_t       ent_q [2];
	logic [1:0] cnt_q;

	logic              acc;
	logic              start;
	logic              tick;
	logic              pop;
	logic [FREQ_W:0]   rem_sh;
	logic              ge;
	logic [FREQ_W:0]   rem_diff;
	logic [PERIOD_W-1:0] quot_nx;
	logic [GAIN_W-1:0] gain_sat;
	logic [PERIOD_W:0] phase_inc;
	logic [TAIL_W-1:0] tail_nx;
	smp_t              new_smp;

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == ST_IDLE) && (cnt_q != 2'd2);
	assign acc       = req.valid && req.ready;
	assign start     = acc && (req.req_type == REQ_START);
	assign tick      = acc && (req.req_type == REQ_TICK);
	assign pop       = smp.valid && smp.ready;

	assign smp.valid   = (cnt_q != 2'd0);
	assign smp.sample  = ent_q[0].sample;
	assign smp.playing = ent_q[0].playing;
	assign smp.in_tail = ent_q[0].in_tail;
	assign smp.last    = ent_q[0].last;

	// shared compare-subtract step of the period division
	assign rem_sh   = {rem_q, DIVIDEND[dcnt_q]};
	assign ge       = rem_sh >= {1'b0, divisor_q};
	assign rem_diff = rem_sh - {1'b0, divisor_q};
	assign quot_nx  = {quot_q[PERIOD_W-2:0], ge};

	assign gain_sat  = (gain_q > FULL_SCALE_GAIN) ? FULL_SCALE_GAIN : gain_q;
	assign phase_inc = {1'b0, phase_q} + (PERIOD_W+1)'(1);
	assign tail_nx   = (tail_q != '0) ? tail_q - TAIL_W'(1) : '0;

	always_comb begin
		new_smp = '0;
		if (busy_q) begin
			new_smp.playing = 1'b1;
			if (frames_q != '0) begin
				if (phase_q < (period_q >> 1)) begin
					new_smp.sample = $signed({1'b0, amp_q});
				end else begin
					new_smp.sample = -$signed({1'b0, amp_q});
				end
			end else begin
				new_smp.in_tail = 1'b1;
				new_smp.last    = (tail_nx == '0);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= FULL_SCALE_GAIN;
		end else if (cfg.valid && cfg.ready) begin
			gain_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			dcnt_q   <= '0;
			period_q <= '0;
			phase_q  <= '0;
			frames_q <= '0;
			tail_q   <= '0;
			amp_q    <= '0;
			busy_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						phase_q  <= '0;
						frames_q <= FRAMES_W'(req.duration_ms) * FRAMES_W'(FRAMES_PER_MS);
						tail_q   <= TAIL_W'(SILENCE_FRAMES);
						amp_q    <= {gain_sat, 14'b0};
						busy_q   <= 1'b1;
						if (req.freq_hz == '0) begin
							period_q <= DEFAULT_PERIOD;
						end else begin
							dcnt_q  <= DCNT_W'(PERIOD_W - 1);
							state_q <= ST_DIV;
						end
					end else if (tick && busy_q) begin
						if (frames_q != '0) begin
							frames_q <= frames_q - FRAMES_W'(1);
							if (phase_inc >= {1'b0, period_q}) begin
								phase_q <= '0;
							end else begin
								phase_q <= phase_inc[PERIOD_W-1:0];
							end
						end else begin
							tail_q <= tail_nx;
							if (tail_nx == '0) begin
								busy_q <= 1'b0;
							end
						end
					end
				end
				ST_DIV: begin
					dcnt_q <= dcnt_q - DCNT_W'(1);
					if (dcnt_q == '0) begin
						period_q <= (quot_nx == '0) ? PERIOD_W'(1) : quot_nx;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			divisor_q <= req.freq_hz;
			rem_q     <= '0;
			quot_q    <= '0;
		end else if (state_q == ST_DIV) begin
			rem_q  <= ge ? rem_diff[FREQ_W-1:0] : rem_sh[FREQ_W-1:0];
			quot_q <= quot_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + 2'(tick) - 2'(pop);
		end
	end

	// hold the head beat until taken; advance the queue on each pop
	always_ff @(posedge clk) begin
		if (tick && ((cnt_q == 2'd0) || (pop && (cnt_q == 2'd1)))) begin
			ent_q[0] <= new_smp;
		end else if (pop) begin
			ent_q[0] <= ent_q[1];
		end
		if (tick && !pop && (cnt_q == 2'd1)) begin
			ent_q[1] <= new_smp;
		end
	end

	a_tick_beat: assert property (@(posedge clk) disable iff (!arst_n)
		tick |=> smp.valid)
		else $error("tick beat not offered");

	a_div_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(start && (req.freq_hz != '0)) |=> (state_q == ST_DIV) && !req.ready)
		else $error("division not started");

	a_period_set: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && (state_q == ST_IDLE)) |-> (period_q != '0))
		else $error("zero period while playing");

	a_tail_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(smp.valid && smp.in_tail) |-> ((smp.sample == '0) && smp.playing))
		else $error("tail beat not silent");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2) |-> !req.ready)
		else $error("queue overrun");

endmodule
`default_nettype wire
